// ----- design/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// prc_pkg
// Shared widths, register indexes and word types for the PR controller.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int SAMPLE_W  = 16;   // error sample
    localparam int COEF_W    = 18;   // Q-format coefficient
    localparam int OUT_W     = 32;   // raw output and drive word
    localparam int OFFS_W    = 16;   // wrapping offset correction
    localparam int SUM_W     = 25;   // window sum
    localparam int MAG_W     = 24;   // magnitude of the window sum
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_X0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_X2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y2 = 3'd4;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_x0;
        logic signed [COEF_W-1:0] coef_x1;
        logic signed [COEF_W-1:0] coef_x2;
        logic signed [COEF_W-1:0] coef_y1;
        logic signed [COEF_W-1:0] coef_y2;
    } t_coefs;

    // word handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic                       close;   // last sample of an averaging window
    } t_item;

endpackage

// ----- design/prc_fifo.sv -----
// ----------------------------------------------------------------------------
// prc_fifo
// Small synchronous queue, first word shown on the read side.
// ----------------------------------------------------------------------------
module prc_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= nxt(r_wptr);
            end
            if (i_rd) begin
                r_rptr <= nxt(r_rptr);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fifo count beyond depth");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("fifo written while full");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("fifo read while empty");

endmodule

// ----- design/prc_front.sv -----
// ----------------------------------------------------------------------------
// prc_front
// Takes sample words, counts the averaging window and tags its last word.
// ----------------------------------------------------------------------------
module prc_front
    import prc_pkg::*;
#(
    parameter int AVG_WINDOW = 400
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic signed [SAMPLE_W-1:0] i_err_sample,
    output logic                       o_full,
    input  logic                       i_q_full,
    output logic                       o_wr,
    output t_item                      o_item
);

    localparam int CNT_W = $clog2(AVG_WINDOW + 1);

    logic [CNT_W-1:0] r_count;
    logic             last;

    assign last         = (r_count == CNT_W'(AVG_WINDOW - 1));
    assign o_full       = i_q_full;
    assign o_wr         = i_push && !i_q_full;
    assign o_item.x     = i_err_sample;
    assign o_item.close = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_wr) begin
            r_count <= last ? '0 : r_count + 1'b1;
        end
    end

    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(AVG_WINDOW))
        else $error("window count out of range");

endmodule

// ----- design/prc_back.sv -----
// ----------------------------------------------------------------------------
// prc_back
// Filter sequencer: shared multiplier, accumulator and window average.
// ----------------------------------------------------------------------------
module prc_back
    import prc_pkg::*;
#(
    parameter int AVG_WINDOW = 400,
    parameter int FRAC_BITS  = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_coefs                  i_coefs,
    input  t_item                   i_item,
    input  logic                    i_q_empty,
    output logic                    o_q_pop,
    input  logic                    i_out_full,
    output logic                    o_out_wr,
    output logic signed [OUT_W-1:0] o_out_data
);

    localparam int REM_W = $clog2(2 * AVG_WINDOW);
    localparam logic [MAG_W:0] DIV_M = (MAG_W + 1)'((64'd1 << MAG_W) / AVG_WINDOW);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_M0   = 3'd1;
    localparam logic [2:0] ST_M1   = 3'd2;
    localparam logic [2:0] ST_M2   = 3'd3;
    localparam logic [2:0] ST_M3   = 3'd4;
    localparam logic [2:0] ST_M4   = 3'd5;
    localparam logic [2:0] ST_ACC  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]                 r_step;
    logic signed [SAMPLE_W-1:0] r_x, r_x1, r_x2;
    logic                       r_close;
    logic signed [OUT_W-1:0]    r_y1, r_y2;
    logic signed [OUT_W-1:0]    r_prod, r_acc;
    logic signed [SUM_W-1:0]    r_sum;
    logic [OFFS_W-1:0]          r_offs;
    logic [MAG_W-1:0]           r_mag, r_q0;
    logic                       r_neg;
    logic [REM_W-1:0]           r_rem;

    logic signed [COEF_W-1:0]          mul_a;
    logic signed [OUT_W-1:0]           mul_b;
    logic signed [COEF_W+OUT_W-1:0]    mul_full;
    logic signed [SUM_W-1:0]           sum_new, sum_abs;
    logic [2*MAG_W:0]                  div_prod;
    logic [MAG_W-1:0]                  qw, rem_full, q_fix;
    logic [OFFS_W-1:0]                 avg;
    logic signed [OUT_W-1:0]           y_val;
    logic                              take;

    // operand select for the shared multiplier
    always_comb begin
        case (r_step)
            ST_M0: begin
                mul_a = i_coefs.coef_x0;
                mul_b = OUT_W'(r_x);
            end
            ST_M1: begin
                mul_a = i_coefs.coef_x1;
                mul_b = OUT_W'(r_x1);
            end
            ST_M2: begin
                mul_a = i_coefs.coef_x2;
                mul_b = OUT_W'(r_x2);
            end
            ST_M3: begin
                mul_a = i_coefs.coef_y1;
                mul_b = r_y1;
            end
            ST_M4: begin
                mul_a = i_coefs.coef_y2;
                mul_b = r_y2;
            end
            default: begin
                mul_a = i_coefs.coef_x0;
                mul_b = OUT_W'(r_x);
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // window average: reciprocal multiply, then one correction step
    assign sum_new  = r_sum + SUM_W'(r_x);
    assign sum_abs  = sum_new[SUM_W-1] ? -sum_new : sum_new;
    assign div_prod = (2 * MAG_W + 1)'(r_mag) * (2 * MAG_W + 1)'(DIV_M);
    assign qw       = r_q0 * MAG_W'(AVG_WINDOW);
    assign rem_full = r_mag - qw;
    assign q_fix    = r_q0 + MAG_W'(r_rem >= REM_W'(AVG_WINDOW));
    assign avg      = r_neg ? (OFFS_W'(0) - q_fix[OFFS_W-1:0]) : q_fix[OFFS_W-1:0];

    assign y_val      = r_acc >>> FRAC_BITS;
    assign o_out_data = y_val + OUT_W'($signed(r_offs));
    assign o_out_wr   = (r_step == ST_DONE) && !i_out_full;
    assign take       = ((r_step == ST_IDLE) || o_out_wr) && !i_q_empty;
    assign o_q_pop    = take;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x     <= i_item.x;
            r_close <= i_item.close;
        end
        r_prod <= mul_full[OUT_W-1:0];
        // sum holds in writeback so a stalled result stays put
        if (r_step == ST_M1) begin
            r_acc <= r_prod;
        end else if (r_step != ST_DONE) begin
            r_acc <= r_acc + r_prod;
        end
        if (r_step == ST_M0) begin
            r_mag <= sum_abs[MAG_W-1:0];
            r_neg <= sum_new[SUM_W-1];
        end
        r_q0  <= div_prod[2*MAG_W-1:MAG_W];
        r_rem <= rem_full[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
            r_x1   <= '0;
            r_x2   <= '0;
            r_y1   <= '0;
            r_y2   <= '0;
            r_sum  <= '0;
            r_offs <= '0;
        end else begin
            case (r_step)
                ST_IDLE: begin
                    if (take) begin
                        r_step <= ST_M0;
                    end
                end
                ST_M0: begin
                    r_sum  <= sum_new;
                    r_step <= ST_M1;
                end
                ST_M1:  r_step <= ST_M2;
                ST_M2:  r_step <= ST_M3;
                ST_M3: begin
                    if (r_close) begin
                        r_offs <= r_offs + avg;
                        r_sum  <= '0;
                    end
                    r_step <= ST_M4;
                end
                ST_M4:  r_step <= ST_ACC;
                ST_ACC: r_step <= ST_DONE;
                ST_DONE: begin
                    if (o_out_wr) begin
                        r_x1   <= r_x;
                        r_x2   <= r_x1;
                        r_y1   <= y_val;
                        r_y2   <= r_y1;
                        r_step <= take ? ST_M0 : ST_IDLE;
                    end
                end
                default: r_step <= ST_IDLE;
            endcase
        end
    end

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_step == ST_IDLE || r_step == ST_DONE))
        else $error("sample taken while filter busy");
    a_window_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_M3 && r_close) |=> r_sum == '0)
        else $error("window sum not cleared on close");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_M2) |=> r_rem <= REM_W'(2 * AVG_WINDOW - 1))
        else $error("average remainder out of range");
    a_hist_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != ST_DONE) |=> $stable(r_y1) && $stable(r_x1))
        else $error("history moved outside writeback");

endmodule

// ----- design/proportional_resonant_controller.sv -----
// ----------------------------------------------------------------------------
// proportional_resonant_controller
// Damped PR current controller with slow window-average offset correction.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  sample    in         push / full  (push & !full)     i_err_sample  s16
//  drive     out        empty / pop  (pop & !empty)     o_drive_out   s32
//  config    in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data s18
//
//  In the back end each word passes through five products on one shared
//  18x32 multiplier, a final accumulate step and a writeback step.
//  Reset is synchronous; coefficients, history, window and offset clear at once.
//  A 4-word queue holds input while the filter works; a 2-word queue holds
//  results, and the filter stalls in writeback when that queue is full.
// ----------------------------------------------------------------------------
module proportional_resonant_controller
    import prc_pkg::*;
#(
    parameter int AVG_WINDOW = 400,
    parameter int FRAC_BITS  = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample words
    input  logic                        push,
    output logic                        full,
    input  logic signed [SAMPLE_W-1:0]  i_err_sample,
    // drive words
    output logic                        empty,
    input  logic                        pop,
    output logic signed [OUT_W-1:0]     o_drive_out,
    // register writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [COEF_W-1:0]           i_cfg_data
);

    t_coefs             r_coefs;
    t_item              fr_item, q_item;
    logic               fr_wr, q_full, q_empty, q_pop;
    logic               out_wr, out_full;
    logic [OUT_W-1:0]   out_data, out_head;

    // registers are always writable; writes must be made only while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_COEF_X0: r_coefs.coef_x0 <= i_cfg_data;
                REG_COEF_X1: r_coefs.coef_x1 <= i_cfg_data;
                REG_COEF_X2: r_coefs.coef_x2 <= i_cfg_data;
                REG_COEF_Y1: r_coefs.coef_y1 <= i_cfg_data;
                REG_COEF_Y2: r_coefs.coef_y2 <= i_cfg_data;
                default: ;   // unknown index: write dropped
            endcase
        end
    end

    // front: window count and tagging of the closing sample
    prc_front #(
        .AVG_WINDOW (AVG_WINDOW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_err_sample (i_err_sample),
        .o_full       (full),
        .i_q_full     (q_full),
        .o_wr         (fr_wr),
        .o_item       (fr_item)
    );

    // queue between front and back
    prc_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (4)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fr_wr),
        .i_wdata (fr_item),
        .o_full  (q_full),
        .i_rd    (q_pop),
        .o_rdata (q_item),
        .o_empty (q_empty)
    );

    // back: filter arithmetic and offset correction
    prc_back #(
        .AVG_WINDOW (AVG_WINDOW),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_coefs    (r_coefs),
        .i_item     (q_item),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_out_full (out_full),
        .o_out_wr   (out_wr),
        .o_out_data (out_data)
    );

    // result queue: decouples writeback from the consumer
    prc_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (out_wr),
        .i_wdata (out_data),
        .o_full  (out_full),
        .i_rd    (pop && !empty),
        .o_rdata (out_head),
        .o_empty (empty)
    );

    assign o_drive_out = out_head;

endmodule

// ----- tb/prc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prc_checker
// Watches the sample, drive and register channels of the PR controller,
// keeps its own copy of the filter state and compares every drive word.
// ----------------------------------------------------------------------------
module prc_checker
    import prc_pkg::*;
#(
    parameter int AVG_WINDOW = 400,
    parameter int FRAC_BITS  = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_full,
    input  logic signed [SAMPLE_W-1:0]  i_err_sample,
    input  logic                        i_empty,
    input  logic                        i_pop,
    input  logic signed [OUT_W-1:0]     i_drive_out,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [COEF_W-1:0]           i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);

    t_coefs                     coefs;
    logic signed [SAMPLE_W-1:0] x_hist [2];
    logic signed [OUT_W-1:0]    y_hist [2];
    logic signed [OFFS_W-1:0]   offset_corr;
    logic [8:0]                 win_count;
    int                         win_sum;
    logic signed [OUT_W-1:0]    drive_q [$];

    // One step of the filter: wrapping Q-format sum, floor shift, window average.
    function automatic logic signed [OUT_W-1:0] predict_drive(
        input logic signed [SAMPLE_W-1:0] x
    );
        longint                  prod_sum;
        logic signed [OUT_W-1:0] acc;
        logic signed [OUT_W-1:0] y;
        int                      avg;
        prod_sum = longint'(coefs.coef_x0) * longint'(x)
                 + longint'(coefs.coef_x1) * longint'(x_hist[0])
                 + longint'(coefs.coef_x2) * longint'(x_hist[1])
                 + longint'(coefs.coef_y1) * longint'(y_hist[0])
                 + longint'(coefs.coef_y2) * longint'(y_hist[1]);
        acc = OUT_W'(prod_sum);
        y   = acc >>> FRAC_BITS;
        win_count = win_count + 9'd1;
        win_sum   = win_sum + int'(x);
        if (win_count >= AVG_WINDOW) begin
            avg         = win_sum / AVG_WINDOW;   // truncates toward zero
            offset_corr = offset_corr + OFFS_W'(avg);
            win_count   = '0;
            win_sum     = 0;
        end
        x_hist[1] = x_hist[0];
        y_hist[1] = y_hist[0];
        x_hist[0] = x;
        y_hist[0] = y;
        return y + offset_corr;
    endfunction

    always @(posedge i_clk) begin : watch
        logic signed [OUT_W-1:0] want;
        logic                    bad;
        bad = 1'b0;
        if (!i_rst_n) begin
            coefs       = '0;
            x_hist[0]   = '0;
            x_hist[1]   = '0;
            y_hist[0]   = '0;
            y_hist[1]   = '0;
            offset_corr = '0;
            win_count   = '0;
            win_sum     = 0;
            drive_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_COEF_X0: coefs.coef_x0 = i_cfg_data;
                    REG_COEF_X1: coefs.coef_x1 = i_cfg_data;
                    REG_COEF_X2: coefs.coef_x2 = i_cfg_data;
                    REG_COEF_Y1: coefs.coef_y1 = i_cfg_data;
                    REG_COEF_Y2: coefs.coef_y2 = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (drive_q.size() == 0) begin
                    $error("drive_out: expected no word, actual %0d", i_drive_out);
                    bad = 1'b1;
                end else begin
                    want = drive_q.pop_front();
                    if (i_drive_out !== want) begin
                        $error("drive_out: expected %0d, actual %0d", want, i_drive_out);
                        bad = 1'b1;
                    end
                end
            end
            if (i_push && !i_full)
                drive_q.push_back(predict_drive(i_err_sample));
        end
        o_pending <= drive_q.size();
        if (bad)
            o_fail_count <= o_fail_count + 1;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the PR controller: register settings from the
// extremes to a damped resonator, directed corner samples, then biased random
// sample words under changing idle patterns; checking lives in prc_checker.
// ----------------------------------------------------------------------------
module tb;
    import prc_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = SAMPLE_W'(2**(SAMPLE_W-1) - 1);
    localparam logic signed [SAMPLE_W-1:0] S_MIN = SAMPLE_W'(-(2**(SAMPLE_W-1)));
    localparam logic signed [COEF_W-1:0]   C_MAX = COEF_W'(2**(COEF_W-1) - 1);
    localparam logic signed [COEF_W-1:0]   C_MIN = COEF_W'(-(2**(COEF_W-1)));
    localparam int N_RANDOM   = 320;   // words per random phase
    localparam int NEG_BIAS   = 80;    // % of words drawn from the strongly negative band
    localparam int HOLD_LEN   = 300;   // receiver hold-off, cycles
    localparam int SMALL_SPAN = 4096;  // +/- range of the gentle coefficient set

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic signed [SAMPLE_W-1:0] i_err_sample = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic signed [OUT_W-1:0]    o_drive_out;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [COEF_W-1:0]          i_cfg_data = '0;

    int fail_count;
    int pending_words;

    int tx_idle_pct = 13;   // sender idle chance per cycle, owned by the stimulus process
    int rx_idle_pct = 71;   // receiver idle chance per cycle, set with NBAs
    int hold_req    = 0;    // bumped by the stimulus to ask for a long hold-off
    int hold_seen   = 0;
    int hold_left   = 0;

    t_coefs cf;

    always #1 i_clk = ~i_clk;

    proportional_resonant_controller dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_err_sample (i_err_sample),
        .empty        (empty),
        .pop          (pop),
        .o_drive_out  (o_drive_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    prc_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_err_sample (i_err_sample),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_drive_out  (o_drive_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    // Receiver: random pop, or a counted hold-off when the stimulus asks for one.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one sample word, after idle cycles drawn one per cycle, and wait
    // for it to be taken.
    // push is left high so back-to-back words never toggle it within one step.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_err_sample <= x;
        do @(posedge i_clk); while (full);
    endtask

    // Stop offering and wait until every predicted drive word has been popped.
    // The pending count is tested only after the clock, so the final pop is counted before the wait ends.
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_coefs(input t_coefs c);
        write_reg(REG_COEF_X0, c.coef_x0);
        write_reg(REG_COEF_X1, c.coef_x1);
        write_reg(REG_COEF_X2, c.coef_x2);
        write_reg(REG_COEF_Y1, c.coef_y1);
        write_reg(REG_COEF_Y2, c.coef_y2);
        i_cfg_valid <= 1'b0;
    endtask

    // span of zero means the full 18-bit range
    function automatic logic signed [COEF_W-1:0] pick_coef(input int span);
        if (span == 0)
            return COEF_W'($urandom);
        return COEF_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic t_coefs rand_coefs(input int span);
        t_coefs c;
        c.coef_x0 = pick_coef(span);
        c.coef_x1 = pick_coef(span);
        c.coef_x2 = pick_coef(span);
        c.coef_y1 = pick_coef(span);
        c.coef_y2 = pick_coef(span);
        return c;
    endfunction

    // Mostly strongly negative samples so that two window averages add up past
    // the 16-bit offset range; the rest full range with a sprinkle of corners.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 5) begin
            case ($urandom_range(3))
                0:       return S_MAX;
                1:       return S_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (r < 5 + NEG_BIAS)
            return SAMPLE_W'(-int'($urandom_range(32768, 15000)));
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_sample(pick_sample());
    endtask

    initial begin
        #1_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // -- directed part --------------------------------------------------
        // Coefficients still at reset: output is only the offset, i.e. zero.
        send_sample(S_MAX);
        send_sample(S_MIN);

        // All weights at the positive extreme: products and sum wrap at 32 bits.
        // Writes to the unused indexes must leave the weights alone.
        drain();
        cf = {5{C_MAX}};
        load_coefs(cf);
        for (int idx = REG_COEF_Y2 + 1; idx < 2**CFG_IDX_W; idx++)
            write_reg(CFG_IDX_W'(idx), '0);
        i_cfg_valid <= 1'b0;
        send_sample(S_MAX);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(-1);
        send_sample(0);
        send_sample(1);

        // Negative extreme.
        drain();
        cf = {5{C_MIN}};
        load_coefs(cf);
        send_sample(S_MIN);
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample(1);
        send_sample(-1);
        send_sample(0);

        // Unit weight on x only: checks the shift floors rather than truncates.
        drain();
        cf = '0;
        cf.coef_x0 = COEF_W'(1);
        load_coefs(cf);
        send_sample(-1);
        send_sample(1);
        send_sample(4095);
        send_sample(-4096);
        send_sample(-4097);

        // -- phase 1: damped resonator, sender mostly busy, receiver lazy ----
        drain();
        cf = '{4096, -8000, 3950, 8093, -4015};
        load_coefs(cf);
        send_random(N_RANDOM / 2);
        drain();   // sender pauses until every drive word is back
        send_random(N_RANDOM - N_RANDOM / 2);

        // -- phase 2: full-range random weights, idle rates swapped ----------
        drain();
        tx_idle_pct  = 71;
        rx_idle_pct <= 13;
        load_coefs(rand_coefs(0));
        send_random(N_RANDOM);

        // -- phase 3: gentle weights, no idling, one long receiver hold-off --
        // The sender keeps offering through the hold-off so both queues fill
        // and full must hold the input back.
        drain();
        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
        load_coefs(rand_coefs(SMALL_SPAN));
        hold_req <= hold_req + 1;
        send_random(N_RANDOM);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
